/* hdl/bmp24_pkg.sv */
// Types, codes and limits shared by the 24-bit bitmap stream decoder.
package bmp24_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [7:0]  MAGIC_B         = 8'h42;
  localparam logic [7:0]  MAGIC_M         = 8'h4D;
  localparam logic [31:0] INFO_SIZE       = 32'd40;
  localparam logic [15:0] PLANES_ONE      = 16'd1;
  localparam logic [15:0] BITS_24         = 16'd24;
  localparam logic [31:0] COLORS_ALLOWED  = 32'd2 << 24;
  localparam logic [31:0] HEADER_BYTES    = 32'd54;

  // header byte positions that close a field
  localparam logic [31:0] POS_MAGIC_0     = 32'd0;
  localparam logic [31:0] POS_MAGIC_1     = 32'd1;
  localparam logic [31:0] POS_OFFSET      = 32'd13;
  localparam logic [31:0] POS_INFO_SIZE   = 32'd17;
  localparam logic [31:0] POS_WIDTH       = 32'd21;
  localparam logic [31:0] POS_HEIGHT      = 32'd25;
  localparam logic [31:0] POS_PLANES      = 32'd27;
  localparam logic [31:0] POS_BITS        = 32'd29;
  localparam logic [31:0] POS_COMPRESSION = 32'd33;
  localparam logic [31:0] POS_COLORS      = 32'd49;
  localparam logic [31:0] POS_IMPORTANT   = 32'd53;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNKNOWN    = 3'd1;
  localparam logic [2:0] ST_CORRUPT    = 3'd2;
  localparam logic [2:0] ST_NOT_24BIT  = 3'd3;
  localparam logic [2:0] ST_COMPRESSED = 3'd4;
  localparam logic [2:0] ST_PALETTE    = 3'd5;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
  } result_item_t;

endpackage

/* hdl/bmp24_stream_decoder.sv */
// Top level of the 24-bit uncompressed bitmap stream decoder.
// Takes one file byte per cycle on the byte channel and returns status and pixel
// transactions on the result channel. Sustained rate is one byte per cycle while
// results are taken; a byte is registered in the input register on acceptance and
// parsed once the result register has space; that step loads its result, if any,
// into the result register, which offers it on the result channel.
// byte_ready drops only while the result register holds a transaction that is
// not being taken. One status transaction follows header byte 53; each third
// pixel byte yields one pixel transaction. Bytes before the first flagged byte,
// after an error or after the last row are dropped until the next first_byte.
module bmp24_stream_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  bmp24_pkg::byte_item_t   byte_data,
  output logic                    result_valid,
  input  logic                    result_ready,
  output bmp24_pkg::result_item_t result_data
);

  bmp24_pkg::byte_item_t   item;
  bmp24_pkg::result_item_t result;
  logic held, space, step, emit;

  assign step = held && space;

  bmp24_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .take       (space),
    .held       (held),
    .item       (item)
  );

  bmp24_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .emit   (emit),
    .result (result)
  );

  bmp24_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && emit),
    .item         (result),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

/* hdl/bmp24_in_reg.sv */
// Input register holding one accepted byte until the parser consumes it.
module bmp24_in_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  bmp24_pkg::byte_item_t byte_data,
  input  logic                  take,
  output logic                  held,
  output bmp24_pkg::byte_item_t item
);

  logic valid;

  assign byte_ready = !valid || take;
  assign held       = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_ready) begin
      valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      item <= byte_data;
    end
  end

endmodule

/* hdl/bmp24_parser.sv */
// Header parser, offset skipper and pixel assembler for one byte per step.
module bmp24_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  bmp24_pkg::byte_item_t   item,
  output logic                    emit,
  output bmp24_pkg::result_item_t result
);

  bmp24_pkg::phase_t phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] data_offset, data_offset_next;
  logic [12:0] width_store, width_store_next;
  logic [12:0] height_store, height_store_next;
  logic [2:0]  pending_error, pending_error_next;
  logic        size_bad, size_bad_next;
  logic [11:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;
  logic [1:0]  channel_index, channel_index_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [1:0]  pad_left, pad_left_next;

  // current view of the state, reset to start-of-file values on a first_byte
  bmp24_pkg::phase_t cur_phase;
  logic [31:0] cur_pos, cur_shift, cur_offset;
  logic [12:0] cur_width, cur_height;
  logic [2:0]  cur_error;
  logic        cur_size_bad;
  logic [11:0] cur_column, cur_row;
  logic [1:0]  cur_channel, cur_pad;
  logic [7:0]  cur_blue, cur_green;

  logic [7:0]  b;
  logic [31:0] shifted;
  logic        emit_status, emit_pixel;
  logic [2:0]  final_status;
  logic        no_pixels;
  logic        row_end, image_end;

  function automatic logic [12:0] sat13(input logic [31:0] v);
    sat13 = (v > 32'd8191) ? 13'h1FFF : v[12:0];
  endfunction

  always_comb begin
    b = item.byte_value;
    if (item.first_byte) begin
      cur_phase    = bmp24_pkg::PH_HEADER;
      cur_pos      = '0;
      cur_shift    = '0;
      cur_offset   = '0;
      cur_width    = '0;
      cur_height   = '0;
      cur_error    = bmp24_pkg::ST_OK;
      cur_size_bad = 1'b0;
      cur_column   = '0;
      cur_row      = '0;
      cur_channel  = '0;
      cur_pad      = '0;
      cur_blue     = '0;
      cur_green    = '0;
    end else begin
      cur_phase    = phase;
      cur_pos      = byte_position;
      cur_shift    = field_shift;
      cur_offset   = data_offset;
      cur_width    = width_store;
      cur_height   = height_store;
      cur_error    = pending_error;
      cur_size_bad = size_bad;
      cur_column   = column_count;
      cur_row      = row_count;
      cur_channel  = channel_index;
      cur_pad      = pad_left;
      cur_blue     = held_blue;
      cur_green    = held_green;
    end
    shifted   = {b, cur_shift[31:8]};
    row_end   = ({1'b0, cur_column} + 13'd1) == cur_width;
    image_end = row_end && (({1'b0, cur_row} + 13'd1) == cur_height);
  end

  // next state
  always_comb begin
    phase_next         = cur_phase;
    byte_position_next = cur_pos;
    field_shift_next   = cur_shift;
    data_offset_next   = cur_offset;
    width_store_next   = cur_width;
    height_store_next  = cur_height;
    pending_error_next = cur_error;
    size_bad_next      = cur_size_bad;
    column_count_next  = cur_column;
    row_count_next     = cur_row;
    channel_index_next = cur_channel;
    held_blue_next     = cur_blue;
    held_green_next    = cur_green;
    pad_left_next      = cur_pad;
    emit_status        = 1'b0;
    emit_pixel         = 1'b0;
    final_status       = bmp24_pkg::ST_OK;
    no_pixels          = 1'b0;

    case (cur_phase)
      bmp24_pkg::PH_HEADER: begin
        field_shift_next   = shifted;
        byte_position_next = cur_pos + 32'd1;
        case (cur_pos)
          bmp24_pkg::POS_MAGIC_0: begin
            if (b != bmp24_pkg::MAGIC_B) pending_error_next = bmp24_pkg::ST_UNKNOWN;
          end
          bmp24_pkg::POS_MAGIC_1: begin
            if (b != bmp24_pkg::MAGIC_M) pending_error_next = bmp24_pkg::ST_UNKNOWN;
          end
          bmp24_pkg::POS_OFFSET: begin
            data_offset_next = shifted;
          end
          bmp24_pkg::POS_INFO_SIZE: begin
            if (shifted != bmp24_pkg::INFO_SIZE && cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_CORRUPT;
          end
          bmp24_pkg::POS_WIDTH: begin
            width_store_next = sat13(shifted);
            if (shifted > 32'(bmp24_pkg::MAX_WIDTH)) size_bad_next = 1'b1;
          end
          bmp24_pkg::POS_HEIGHT: begin
            height_store_next = sat13(shifted);
            if (shifted > 32'(bmp24_pkg::MAX_HEIGHT)) size_bad_next = 1'b1;
          end
          bmp24_pkg::POS_PLANES: begin
            if (shifted[31:16] != bmp24_pkg::PLANES_ONE &&
                cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_CORRUPT;
          end
          bmp24_pkg::POS_BITS: begin
            if (shifted[31:16] != bmp24_pkg::BITS_24 && cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_NOT_24BIT;
          end
          bmp24_pkg::POS_COMPRESSION: begin
            if (shifted != '0 && cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_COMPRESSED;
          end
          bmp24_pkg::POS_COLORS: begin
            if (shifted != '0 && shifted != bmp24_pkg::COLORS_ALLOWED &&
                cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_PALETTE;
          end
          bmp24_pkg::POS_IMPORTANT: begin
            if (shifted != '0 && cur_error != bmp24_pkg::ST_UNKNOWN)
              pending_error_next = bmp24_pkg::ST_PALETTE;
          end
          default: begin
          end
        endcase
        if (cur_pos == bmp24_pkg::POS_IMPORTANT) begin
          emit_status  = 1'b1;
          final_status = pending_error_next;
          if (final_status == bmp24_pkg::ST_OK &&
              (cur_offset < bmp24_pkg::HEADER_BYTES || size_bad_next))
            final_status = bmp24_pkg::ST_CORRUPT;
          no_pixels = (final_status != bmp24_pkg::ST_OK) ||
                      (cur_width == '0) || (cur_height == '0);
          if (no_pixels) begin
            phase_next = bmp24_pkg::PH_DONE;
          end else if (cur_offset == bmp24_pkg::HEADER_BYTES) begin
            phase_next = bmp24_pkg::PH_PIXEL;
          end else begin
            phase_next = bmp24_pkg::PH_SKIP;
          end
          pad_left_next = '0;
        end
      end
      bmp24_pkg::PH_SKIP, bmp24_pkg::PH_PIXEL: begin
        if (cur_phase == bmp24_pkg::PH_SKIP && cur_pos < cur_offset) begin
          byte_position_next = cur_pos + 32'd1;
        end else begin
          phase_next = bmp24_pkg::PH_PIXEL;
          if (cur_pad != '0) begin
            pad_left_next = cur_pad - 2'd1;
          end else if (cur_channel == 2'd0) begin
            held_blue_next     = b;
            channel_index_next = 2'd1;
          end else if (cur_channel == 2'd1) begin
            held_green_next    = b;
            channel_index_next = 2'd2;
          end else begin
            emit_pixel         = 1'b1;
            channel_index_next = 2'd0;
            if (row_end) begin
              column_count_next = '0;
              row_count_next    = cur_row + 12'd1;
              pad_left_next     = cur_width[1:0];
              if (image_end) phase_next = bmp24_pkg::PH_DONE;
            end else begin
              column_count_next = cur_column + 12'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    result = '0;
    emit   = emit_status || emit_pixel;
    if (emit_status) begin
      result.kind         = bmp24_pkg::KIND_STATUS;
      result.status       = final_status;
      result.image_width  = cur_width;
      result.image_height = cur_height;
      result.last_pixel   = no_pixels;
    end else if (emit_pixel) begin
      result.kind       = bmp24_pkg::KIND_PIXEL;
      result.red        = b;
      result.green      = cur_green;
      result.blue       = cur_blue;
      result.column     = cur_column;
      result.row        = cur_row;
      result.last_pixel = image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bmp24_pkg::PH_IDLE;
      byte_position <= '0;
      field_shift   <= '0;
      data_offset   <= '0;
      width_store   <= '0;
      height_store  <= '0;
      pending_error <= bmp24_pkg::ST_OK;
      size_bad      <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      channel_index <= '0;
      held_blue     <= '0;
      held_green    <= '0;
      pad_left      <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      field_shift   <= field_shift_next;
      data_offset   <= data_offset_next;
      width_store   <= width_store_next;
      height_store  <= height_store_next;
      pending_error <= pending_error_next;
      size_bad      <= size_bad_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      channel_index <= channel_index_next;
      held_blue     <= held_blue_next;
      held_green    <= held_green_next;
      pad_left      <= pad_left_next;
    end
  end

endmodule

/* hdl/bmp24_out_reg.sv */
// Result register presenting one decoded item until the consumer takes it.
module bmp24_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  bmp24_pkg::result_item_t item,
  output logic                    space,
  output logic                    result_valid,
  input  logic                    result_ready,
  output bmp24_pkg::result_item_t result_data
);

  logic valid;

  assign space        = !valid || result_ready;
  assign result_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      result_data <= item;
    end
  end

endmodule

/* sim/bmp24_stream_decoder_tb.sv */
// Self-checking testbench: bitmap byte streams in, predicted status and pixel transactions out.
`timescale 1ns / 100ps

module bmp24_stream_decoder_tb;

  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int TOTAL_BYTES  = 600;

  typedef struct {
    bmp24_pkg::byte_item_t item;
    bit                    hold;
  } file_byte_t;

  typedef struct {
    logic [15:0] magic;
    logic [31:0] offset;
    logic [31:0] info_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [15:0] bits;
    logic [31:0] compression;
    logic [31:0] colors;
    logic [31:0] important;
    int          cut;
    int          trailing;
    int          hold_at;
  } bmp_layout_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    byte_valid = 1'b0;
  logic                    byte_ready;
  bmp24_pkg::byte_item_t   byte_data = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  bmp24_pkg::result_item_t result_data;

  file_byte_t              file_bytes[$];
  bmp24_pkg::result_item_t decoded_items[$];
  bmp24_pkg::result_item_t want;
  int                      mismatches = 0;
  int                      quiet_cycles = 0;
  int                      send_gap = 0;
  int                      recv_wait = 0;
  int                      recv_draw;
  bit                      send_calm = 1'b0;
  bit                      recv_calm = 1'b0;

  bmp24_pkg::phase_t       dec_phase = bmp24_pkg::PH_IDLE;
  logic [31:0]             hdr_pos;
  logic [31:0]             shift_reg;
  logic [31:0]             pix_offset;
  logic [31:0]             img_w;
  logic [31:0]             img_h;
  logic [2:0]              fault;
  bit                      oversize;
  logic [31:0]             col;
  logic [31:0]             rowc;
  logic [1:0]              chan;
  logic [7:0]              keep_b;
  logic [7:0]              keep_g;
  logic [1:0]              pad_cnt;

  bmp24_stream_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void restart_parse();
    dec_phase  = bmp24_pkg::PH_HEADER;
    hdr_pos    = '0;
    shift_reg  = '0;
    pix_offset = '0;
    img_w      = '0;
    img_h      = '0;
    fault      = bmp24_pkg::ST_OK;
    oversize   = 1'b0;
    col        = '0;
    rowc       = '0;
    chan       = '0;
    keep_b     = '0;
    keep_g     = '0;
    pad_cnt    = '0;
  endfunction

  function automatic void note_fault(input logic [2:0] code);
    if (fault != bmp24_pkg::ST_UNKNOWN) fault = code;
  endfunction

  function automatic void read_header(input logic [7:0] b);
    logic [2:0]              verdict;
    bit                      empty;
    bmp24_pkg::result_item_t st_item;
    shift_reg = {b, shift_reg[31:8]};
    case (hdr_pos)
      bmp24_pkg::POS_MAGIC_0: if (b != bmp24_pkg::MAGIC_B) fault = bmp24_pkg::ST_UNKNOWN;
      bmp24_pkg::POS_MAGIC_1: if (b != bmp24_pkg::MAGIC_M) fault = bmp24_pkg::ST_UNKNOWN;
      bmp24_pkg::POS_OFFSET: pix_offset = shift_reg;
      bmp24_pkg::POS_INFO_SIZE: begin
        if (shift_reg != bmp24_pkg::INFO_SIZE) note_fault(bmp24_pkg::ST_CORRUPT);
      end
      bmp24_pkg::POS_WIDTH: begin
        img_w = shift_reg;
        if (shift_reg > bmp24_pkg::MAX_WIDTH) oversize = 1'b1;
      end
      bmp24_pkg::POS_HEIGHT: begin
        img_h = shift_reg;
        if (shift_reg > bmp24_pkg::MAX_HEIGHT) oversize = 1'b1;
      end
      bmp24_pkg::POS_PLANES: begin
        if (shift_reg[31:16] != bmp24_pkg::PLANES_ONE) note_fault(bmp24_pkg::ST_CORRUPT);
      end
      bmp24_pkg::POS_BITS: begin
        if (shift_reg[31:16] != bmp24_pkg::BITS_24) note_fault(bmp24_pkg::ST_NOT_24BIT);
      end
      bmp24_pkg::POS_COMPRESSION: begin
        if (shift_reg != '0) note_fault(bmp24_pkg::ST_COMPRESSED);
      end
      bmp24_pkg::POS_COLORS: begin
        if (shift_reg != '0 && shift_reg != bmp24_pkg::COLORS_ALLOWED)
          note_fault(bmp24_pkg::ST_PALETTE);
      end
      bmp24_pkg::POS_IMPORTANT: begin
        if (shift_reg != '0) note_fault(bmp24_pkg::ST_PALETTE);
      end
      default: ;
    endcase
    if (hdr_pos == bmp24_pkg::POS_IMPORTANT) begin
      verdict = fault;
      if (verdict == bmp24_pkg::ST_OK &&
          (pix_offset < bmp24_pkg::HEADER_BYTES || oversize))
        verdict = bmp24_pkg::ST_CORRUPT;
      empty = (img_w == '0 || img_h == '0);
      st_item = '0;
      st_item.kind         = bmp24_pkg::KIND_STATUS;
      st_item.status       = verdict;
      st_item.image_width  = (img_w > 32'd8191) ? 13'h1FFF : img_w[12:0];
      st_item.image_height = (img_h > 32'd8191) ? 13'h1FFF : img_h[12:0];
      st_item.last_pixel   = (verdict != bmp24_pkg::ST_OK || empty);
      decoded_items.push_back(st_item);
      if (verdict != bmp24_pkg::ST_OK || empty) begin
        dec_phase = bmp24_pkg::PH_DONE;
      end else begin
        dec_phase = (pix_offset == bmp24_pkg::HEADER_BYTES) ? bmp24_pkg::PH_PIXEL :
                                                              bmp24_pkg::PH_SKIP;
        pad_cnt = '0;
      end
    end
    hdr_pos = hdr_pos + 32'd1;
  endfunction

  function automatic void read_pixel_byte(input logic [7:0] b);
    bmp24_pkg::result_item_t px;
    if (pad_cnt != '0) begin
      pad_cnt = pad_cnt - 2'd1;
      return;
    end
    if (chan == 2'd0) begin
      keep_b = b;
      chan = 2'd1;
      return;
    end
    if (chan == 2'd1) begin
      keep_g = b;
      chan = 2'd2;
      return;
    end
    chan = 2'd0;
    px = '0;
    px.kind       = bmp24_pkg::KIND_PIXEL;
    px.red        = b;
    px.green      = keep_g;
    px.blue       = keep_b;
    px.column     = col[11:0];
    px.row        = rowc[11:0];
    px.last_pixel = (col + 32'd1 == img_w && rowc + 32'd1 == img_h);
    decoded_items.push_back(px);
    col = col + 32'd1;
    if (col >= img_w) begin
      col = '0;
      rowc = rowc + 32'd1;
      // row of 3*w bytes pads up to a multiple of four
      pad_cnt = img_w[1:0];
      if (rowc >= img_h) dec_phase = bmp24_pkg::PH_DONE;
    end
  endfunction

  function automatic void decode_byte(input bmp24_pkg::byte_item_t it);
    if (it.first_byte) restart_parse();
    case (dec_phase)
      bmp24_pkg::PH_HEADER: read_header(it.byte_value);
      bmp24_pkg::PH_SKIP: begin
        if (hdr_pos < pix_offset) begin
          hdr_pos = hdr_pos + 32'd1;
        end else begin
          dec_phase = bmp24_pkg::PH_PIXEL;
          read_pixel_byte(it.byte_value);
        end
      end
      bmp24_pkg::PH_PIXEL: read_pixel_byte(it.byte_value);
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) q.push_back(v[8*k +: 8]);
  endtask

  function automatic bmp_layout_t plain_layout(input logic [31:0] w, input logic [31:0] h);
    bmp_layout_t f;
    f.magic       = {bmp24_pkg::MAGIC_M, bmp24_pkg::MAGIC_B};
    f.offset      = bmp24_pkg::HEADER_BYTES;
    f.info_size   = bmp24_pkg::INFO_SIZE;
    f.width       = w;
    f.height      = h;
    f.planes      = bmp24_pkg::PLANES_ONE;
    f.bits        = bmp24_pkg::BITS_24;
    f.compression = '0;
    f.colors      = '0;
    f.important   = '0;
    f.cut         = 0;
    f.trailing    = 0;
    f.hold_at     = -1;
    return f;
  endfunction

  task automatic add_noise(input int n, input bit allow_restart);
    file_byte_t e;
    repeat (n) begin
      e.item.byte_value = noisy_byte();
      e.item.first_byte = allow_restart && ($urandom_range(0, 15) == 0);
      e.hold = 1'b0;
      file_bytes.push_back(e);
    end
  endtask

  task automatic add_file(input bmp_layout_t f);
    logic [7:0] img[$];
    file_byte_t e;
    int         keep;
    put_le(img, 32'(f.magic), 2);
    put_le(img, $urandom, 4);
    put_le(img, $urandom, 4);
    put_le(img, f.offset, 4);
    put_le(img, f.info_size, 4);
    put_le(img, f.width, 4);
    put_le(img, f.height, 4);
    put_le(img, 32'(f.planes), 2);
    put_le(img, 32'(f.bits), 2);
    put_le(img, f.compression, 4);
    put_le(img, $urandom, 4);
    put_le(img, $urandom, 4);
    put_le(img, $urandom, 4);
    put_le(img, f.colors, 4);
    put_le(img, f.important, 4);
    if (f.width <= 16 && f.height <= 16 && f.offset >= bmp24_pkg::HEADER_BYTES &&
        f.offset <= 80) begin
      repeat (f.offset - bmp24_pkg::HEADER_BYTES) img.push_back(noisy_byte());
      repeat (f.height) begin
        repeat (3 * f.width + f.width[1:0]) img.push_back(noisy_byte());
      end
    end
    repeat (f.trailing) img.push_back(noisy_byte());
    keep = (f.cut > 0 && f.cut < img.size()) ? f.cut : img.size();
    for (int i = 0; i < keep; i++) begin
      e.item.byte_value = img[i];
      e.item.first_byte = (i == 0);
      e.hold = (i == f.hold_at);
      file_bytes.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches = mismatches + 1;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (byte_valid && byte_ready) decode_byte(byte_data);
      if (!byte_valid || byte_ready) begin
        if (send_gap != 0) begin
          byte_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (file_bytes.size() != 0 &&
                     !(file_bytes[0].hold && decoded_items.size() != 0)) begin
          byte_valid <= 1'b1;
          byte_data <= file_bytes[0].item;
          void'(file_bytes.pop_front());
          if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
          send_gap <= send_calm ? 0 : $urandom_range(0, 3);
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (decoded_items.size() == 0) begin
          $display("%0t ns: expected no transaction, got %p", $time, result_data);
          mismatches = mismatches + 1;
        end else begin
          want = decoded_items.pop_front();
          check_field("kind", 32'(want.kind), 32'(result_data.kind));
          check_field("status", 32'(want.status), 32'(result_data.status));
          check_field("image_width", 32'(want.image_width), 32'(result_data.image_width));
          check_field("image_height", 32'(want.image_height),
                      32'(result_data.image_height));
          check_field("red", 32'(want.red), 32'(result_data.red));
          check_field("green", 32'(want.green), 32'(result_data.green));
          check_field("blue", 32'(want.blue), 32'(result_data.blue));
          check_field("column", 32'(want.column), 32'(result_data.column));
          check_field("row", 32'(want.row), 32'(result_data.row));
          check_field("last_pixel", 32'(want.last_pixel), 32'(result_data.last_pixel));
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_draw = recv_calm ? 0 : $urandom_range(0, 3);
        recv_wait <= recv_draw;
        result_ready <= (recv_draw == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        result_ready <= (recv_wait == 1);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL bmp24_stream_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bmp_layout_t f;

    add_noise(3, 1'b0);
    f = plain_layout(3, 2); f.colors = bmp24_pkg::COLORS_ALLOWED; f.hold_at = 54;
    f.trailing = 3; add_file(f);
    f = plain_layout(1, 3); f.offset = 57; add_file(f);
    f = plain_layout(2, 2); f.magic[7:0] = 8'h43; f.bits = 16'd8; f.cut = 54; add_file(f);
    f = plain_layout(2, 2); f.info_size = 12; f.bits = 16'd8; f.compression = 1;
    f.cut = 54; add_file(f);
    f = plain_layout(2, 2); f.planes = 16'd0; f.important = 1; f.cut = 54; add_file(f);
    f = plain_layout(2, 2); f.info_size = 108; f.bits = 16'd32; f.cut = 54; add_file(f);
    f = plain_layout(2, 2); f.offset = 40; add_file(f);
    f = plain_layout(32'hFFFF_FFFF, 2); add_file(f);
    f = plain_layout(0, 3); f.trailing = 2; add_file(f);
    f = plain_layout(2, 2); f.cut = 20; add_file(f);

    while (file_bytes.size() < TOTAL_BYTES) begin
      f = plain_layout($urandom_range(0, 6), $urandom_range(0, 4));
      if ($urandom_range(0, 15) == 0)
        f.width = ($urandom_range(0, 1) == 0) ? bmp24_pkg::MAX_WIDTH + 1 : $urandom;
      if ($urandom_range(0, 15) == 0)
        f.height = ($urandom_range(0, 1) == 0) ? bmp24_pkg::MAX_HEIGHT : $urandom;
      case ($urandom_range(0, 7))
        0: f.offset = bmp24_pkg::HEADER_BYTES + $urandom_range(1, 8);
        1: f.offset = $urandom_range(0, 53);
        2: if ($urandom_range(0, 3) == 0) f.offset = $urandom;
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) f.magic = 16'($urandom);
      if ($urandom_range(0, 19) == 0) f.info_size = $urandom_range(0, 64);
      if ($urandom_range(0, 19) == 0) f.planes = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) f.bits = 16'($urandom_range(0, 32));
      if ($urandom_range(0, 19) == 0) f.compression = $urandom;
      if ($urandom_range(0, 9) == 0)
        f.colors = ($urandom_range(0, 1) == 0) ? bmp24_pkg::COLORS_ALLOWED : $urandom;
      if ($urandom_range(0, 19) == 0) f.important = $urandom;
      f.trailing = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) f.cut = $urandom_range(1, 70);
      if ($urandom_range(0, 4) == 0) f.hold_at = $urandom_range(0, 60);
      add_file(f);
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4), 1'b1);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (file_bytes.size() != 0 || byte_valid || decoded_items.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS bmp24_stream_decoder");
    end else begin
      $display("FAIL bmp24_stream_decoder");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bmp24_pkg.sv
hdl/bmp24_in_reg.sv
hdl/bmp24_parser.sv
hdl/bmp24_out_reg.sv
hdl/bmp24_stream_decoder.sv
sim/bmp24_stream_decoder_tb.sv
